### rtl/gbnr_pkg.sv
package gbnr_pkg;

	localparam int HISTORY_DEPTH = 20;

	localparam int WORD_W      = 16;
	localparam int SEQ_W       = 31;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 32;

	localparam logic [WORD_W-1:0] SUM_OK    = 16'hFFFF;
	localparam logic [SEQ_W-1:0]  SEQ_RESET = 31'd1;

	// input item kinds, carried on tuser
	localparam logic KIND_WORD = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic acc_add;
		logic acc_clear;
		logic ack_load;
		logic rep_start;
		logic rep_load;
	} cmd_t;

	typedef struct packed {
		logic valid_pkt;
		logic in_order;
		logic hist_empty;
		logic out_free;
		logic rep_last;
	} status_t;

endpackage

### rtl/gbnr_ctrl.sv
module gbnr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_kind,
	output logic                s_tready,
	input  gbnr_pkg::status_t   status,
	output gbnr_pkg::cmd_t      cmd
);

	gbnr_pkg::state_t state_q, state_d;
	logic fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbnr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		fire     = 1'b0;
		case (state_q)
			gbnr_pkg::ST_IDLE: begin
				s_tready = status.out_free;
				fire     = s_tvalid && status.out_free;
				if (fire) begin
					if (s_kind == gbnr_pkg::KIND_WORD) begin
						cmd.acc_add = 1'b1;
					end else begin
						cmd.acc_clear = 1'b1;
						if (status.valid_pkt) begin
							if (status.in_order) begin
								cmd.ack_load = 1'b1;
							end else if (!status.hist_empty) begin
								cmd.rep_start = 1'b1;
								state_d       = gbnr_pkg::ST_FETCH;
							end
						end
					end
				end
			end
			// wait state for the registered history read
			gbnr_pkg::ST_FETCH: begin
				state_d = gbnr_pkg::ST_EMIT;
			end
			gbnr_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.rep_load = 1'b1;
					state_d      = status.rep_last ? gbnr_pkg::ST_IDLE : gbnr_pkg::ST_FETCH;
				end
			end
			default: begin
				state_d = gbnr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/gbnr_dp.sv
module gbnr_dp #(
	parameter int HISTORY_DEPTH = gbnr_pkg::HISTORY_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [gbnr_pkg::S_TDATA_W-1:0]    s_tdata,
	input  gbnr_pkg::cmd_t                    cmd,
	output gbnr_pkg::status_t                 status,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [gbnr_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HISTORY_DEPTH - 1);
	localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(HISTORY_DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [gbnr_pkg::WORD_W-1:0] word;
	logic [gbnr_pkg::SEQ_W-1:0]  seq;
	logic                        has_payload;

	logic [gbnr_pkg::WORD_W-1:0] acc_q;
	logic [gbnr_pkg::SEQ_W-1:0]  exp_q;
	logic [PTR_W-1:0]            wr_q;
	logic [PTR_W-1:0]            rd_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [CNT_W-1:0]            rem_q;

	logic [gbnr_pkg::SEQ_W-1:0]  mem [HISTORY_DEPTH];
	logic [gbnr_pkg::SEQ_W-1:0]  rd_data_q;

	logic                        out_valid_q;
	logic [gbnr_pkg::SEQ_W-1:0]  out_ack_q;
	logic                        out_rep_q;
	logic                        out_last_q;

	logic [gbnr_pkg::WORD_W:0]   sum;
	logic [gbnr_pkg::WORD_W-1:0] acc_next;
	logic [PTR_W:0]              wr_ext;
	logic [PTR_W:0]              cnt_ext;
	logic [PTR_W:0]              start_ext;
	logic                        out_free;

	assign word        = s_tdata[15:0];
	assign seq         = s_tdata[46:16];
	assign has_payload = s_tdata[47];

	// ones' complement add: end-around carry cannot carry again
	assign sum      = {1'b0, acc_q} + {1'b0, word};
	assign acc_next = sum[gbnr_pkg::WORD_W-1:0] + {{(gbnr_pkg::WORD_W-1){1'b0}}, sum[gbnr_pkg::WORD_W]};

	// oldest entry: wr - cnt modulo depth
	assign wr_ext    = {1'b0, wr_q};
	assign cnt_ext   = (PTR_W + 1)'(cnt_q);
	assign start_ext = (wr_ext >= cnt_ext) ? (wr_ext - cnt_ext) : (wr_ext + DEPTH_X - cnt_ext);

	assign out_free = !out_valid_q || m_tready;

	assign status.valid_pkt  = (acc_q == gbnr_pkg::SUM_OK) && has_payload;
	assign status.in_order   = (seq == exp_q);
	assign status.hist_empty = (cnt_q == '0);
	assign status.out_free   = out_free;
	assign status.rep_last   = (rem_q == CNT_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			exp_q <= gbnr_pkg::SEQ_RESET;
			wr_q  <= '0;
			cnt_q <= '0;
			rd_q  <= '0;
			rem_q <= '0;
		end else begin
			if (cmd.acc_add) begin
				acc_q <= acc_next;
			end else if (cmd.acc_clear) begin
				acc_q <= '0;
			end
			if (cmd.ack_load) begin
				exp_q <= exp_q + 1'b1;
				wr_q  <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
				if (cnt_q != CNT_FULL) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.rep_start) begin
				rd_q  <= start_ext[PTR_W-1:0];
				rem_q <= cnt_q;
			end else if (cmd.rep_load) begin
				rd_q  <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ack_load) begin
			mem[wr_q] <= exp_q;
		end
		rd_data_q <= mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ack_load || cmd.rep_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ack_load) begin
			out_ack_q  <= exp_q;
			out_rep_q  <= 1'b0;
			out_last_q <= 1'b1;
		end else if (cmd.rep_load) begin
			out_ack_q  <= rd_data_q;
			out_rep_q  <= 1'b1;
			out_last_q <= (rem_q == CNT_ONE);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_ack_q};
	assign m_tuser  = out_rep_q;
	assign m_tlast  = out_last_q;

endmodule

### rtl/go_back_n_receiver_with_ack_replay.sv
// Channel   Direction  tdata (low bit up)                      tuser       tlast
// s_axis    in         word[15:0] seq[46:16] has_payload[47]   kind        -
// m_axis    out        ack_number[30:0], zero[31]              is_replay   last
//
// Packet words and end beats are taken one a cycle while idle and the output register is free.
// A valid in-order end beat puts its ACK in the output register in the same cycle.
// A replay steps through FETCH (registered history read) and EMIT (load) for each remembered
// ACK, oldest first, during which s_axis_tready is low.
// Reset sets the expected number to 1 and empties the history; no clearing pass.
// A stalled m_axis holds its beat; outside a replay, s_axis waits only if that beat is not taken.
module go_back_n_receiver_with_ack_replay #(
	parameter int HISTORY_DEPTH = gbnr_pkg::HISTORY_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [gbnr_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // word, seq, has_payload
	input  logic                              s_axis_tuser,   // kind
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [gbnr_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // ack_number
	output logic                              m_axis_tuser,   // is_replay
	output logic                              m_axis_tlast
);

	gbnr_pkg::cmd_t    cmd;
	gbnr_pkg::status_t status;

	gbnr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_kind   (s_axis_tuser),
		.s_tready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gbnr_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_axis_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tready (m_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser),
		.m_tlast  (m_axis_tlast)
	);

endmodule

### rtl/gbnr_chk.sv
module gbnr_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [gbnr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	input logic                              m_axis_tuser,
	input logic                              m_axis_tlast
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// an in-order ACK is always the only beat of its burst
	a_fresh_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("in-order ACK without tlast");

	// input is held off while a replay beat other than the last is on the output
	a_replay_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken during replay burst");

	// input only taken when the output register can take a result
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
		else $error("input ready with output register blocked");

	// padding bit of the ACK stays clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[gbnr_pkg::M_TDATA_W-1])
		else $error("ACK padding bit set");

endmodule

bind go_back_n_receiver_with_ack_replay gbnr_chk u_gbnr_chk (.*);
